/* design/sd7seg_pkg.sv */
// Shared types, constants and functions for the signed decimal seven-segment writer.
`default_nettype none

package sd7seg_pkg;

   // Width of the signed input number
   localparam int VALUE_WIDTH = 32;

   // Decimal digits that hold any magnitude up to 2**(VALUE_WIDTH-1)
   localparam int NUM_DIGITS = (VALUE_WIDTH * 3) / 10 + 1;
   localparam int BCD_WIDTH  = NUM_DIGITS * 4;

   // Counter widths for the shift loop and the digit scan
   localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);
   localparam int DCNT_WIDTH  = $clog2(NUM_DIGITS + 1);

   // Field widths of one display write
   localparam int ADDR_WIDTH = 5;
   localparam int SEG_WIDTH  = 8;
   localparam int POS_WIDTH  = ADDR_WIDTH - 1;

   // Segment codes
   localparam logic [SEG_WIDTH-1:0] SEG_MINUS = 8'h40;
   localparam logic [SEG_WIDTH-1:0] SEG_BLANK = 8'h00;
   localparam logic [SEG_WIDTH-1:0] SEG_TABLE [10] = '{
      8'hBE, 8'h06, 8'h7C, 8'h5E, 8'hC6,
      8'hDA, 8'hF2, 8'h0E, 8'hFE, 8'hCE
   };

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   // Map one decimal digit to its segment pattern
   function automatic logic [SEG_WIDTH-1:0] seg_code(input logic [3:0] digit);
      logic [SEG_WIDTH-1:0] code;
      if (digit <= 4'd9) begin
         code = SEG_TABLE[digit];
      end else begin
         code = SEG_BLANK;
      end
      return code;
   endfunction

   // Add three to every digit of five or more before the next shift
   function automatic logic [BCD_WIDTH-1:0] bcd_adjust(input logic [BCD_WIDTH-1:0] bcd);
      logic [BCD_WIDTH-1:0] result;
      result = bcd;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd[i*4 +: 4] >= 4'd5) begin
            result[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
         end
      end
      return result;
   endfunction

endpackage

`default_nettype wire

/* design/sd7seg_dabble.sv */
// Bit-serial binary to BCD converter, one magnitude bit per cycle.
`default_nettype none

module sd7seg_dabble (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [sd7seg_pkg::VALUE_WIDTH-1:0]    magnitude,
   output logic                                       done,
   output logic [sd7seg_pkg::BCD_WIDTH-1:0]           bcd
);

   logic                                    busy_ff;
   logic                                    done_ff;
   logic [sd7seg_pkg::COUNT_WIDTH-1:0]      count_ff;
   logic [sd7seg_pkg::VALUE_WIDTH-1:0]      mag_ff;
   logic [sd7seg_pkg::BCD_WIDTH-1:0]        bcd_ff;
   logic [sd7seg_pkg::BCD_WIDTH-1:0]        adjusted;

   assign adjusted = sd7seg_pkg::bcd_adjust(bcd_ff);

   // Track the shift loop
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && (count_ff == sd7seg_pkg::COUNT_WIDTH'(1));
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= sd7seg_pkg::COUNT_WIDTH'(sd7seg_pkg::VALUE_WIDTH);
         end else if (busy_ff) begin
            count_ff <= count_ff - sd7seg_pkg::COUNT_WIDTH'(1);
            if (count_ff == sd7seg_pkg::COUNT_WIDTH'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Shift one magnitude bit into the adjusted digits
   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= magnitude;
         bcd_ff <= '0;
      end else if (busy_ff) begin
         mag_ff <= {mag_ff[sd7seg_pkg::VALUE_WIDTH-2:0], 1'b0};
         bcd_ff <= {adjusted[sd7seg_pkg::BCD_WIDTH-2:0], mag_ff[sd7seg_pkg::VALUE_WIDTH-1]};
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

`default_nettype wire

/* design/signed_decimal_to_seven_segment.sv */
// Top level: signed number in, one seven-segment display write per character out.
// Flow: the magnitude is converted to BCD by a bit-serial shift loop, one bit per cycle,
// then leading zeros are dropped one digit at a time, keeping at least one digit; then
// one character is written per cycle while the output is not stalled.
// Requests: one number at a time; req_stall stays high from acceptance until the last
// character has been put on the output.
// Reset: synchronous, active high; clears the controller, the shift loop and the output valid.
`default_nettype none

module signed_decimal_to_seven_segment (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [sd7seg_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [sd7seg_pkg::ADDR_WIDTH-1:0]           rsp_digit_address,
   output logic [sd7seg_pkg::SEG_WIDTH-1:0]            rsp_segments,
   output logic                                        rsp_last_char
);

   sd7seg_pkg::state_type                   state_ff, state_in;
   logic                                    sign_pend_ff, sign_pend_in;
   logic [sd7seg_pkg::BCD_WIDTH-1:0]        digit_sr_ff, digit_sr_in;
   logic [sd7seg_pkg::DCNT_WIDTH-1:0]       left_ff, left_in;
   logic [sd7seg_pkg::POS_WIDTH-1:0]        pos_ff, pos_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [sd7seg_pkg::ADDR_WIDTH-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [sd7seg_pkg::SEG_WIDTH-1:0]        rsp_seg_ff, rsp_seg_in;
   logic                                    rsp_last_ff, rsp_last_in;

   logic [sd7seg_pkg::VALUE_WIDTH-1:0]      value_bits;
   logic [sd7seg_pkg::VALUE_WIDTH-1:0]      magnitude;
   logic                                    start;
   logic                                    conv_done;
   logic [sd7seg_pkg::BCD_WIDTH-1:0]        conv_bcd;
   logic [3:0]                              top_digit;
   logic                                    slot_free;
   logic                                    final_digit;

   // Form the unsigned magnitude; the most negative value maps to itself
   assign value_bits = $unsigned(req_value);
   assign magnitude  = value_bits[sd7seg_pkg::VALUE_WIDTH-1]
                       ? (sd7seg_pkg::VALUE_WIDTH'(0) - value_bits) : value_bits;

   assign req_stall = (state_ff != sd7seg_pkg::ST_IDLE);
   assign start     = req_valid && !req_stall;

   sd7seg_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .magnitude (magnitude),
      .done      (conv_done),
      .bcd       (conv_bcd)
   );

   assign top_digit   = digit_sr_ff[sd7seg_pkg::BCD_WIDTH-1 -: 4];
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign final_digit = (left_ff == sd7seg_pkg::DCNT_WIDTH'(1));

   // Sequence conversion, leading-zero drop and character writes
   always_comb begin
      state_in     = state_ff;
      sign_pend_in = sign_pend_ff;
      digit_sr_in  = digit_sr_ff;
      left_in      = left_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_addr_in  = rsp_addr_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         sd7seg_pkg::ST_IDLE: begin
            if (start) begin
               sign_pend_in = value_bits[sd7seg_pkg::VALUE_WIDTH-1];
               pos_in       = '0;
               state_in     = sd7seg_pkg::ST_CONVERT;
            end
         end
         sd7seg_pkg::ST_CONVERT: begin
            if (conv_done) begin
               digit_sr_in = conv_bcd;
               left_in     = sd7seg_pkg::DCNT_WIDTH'(sd7seg_pkg::NUM_DIGITS);
               state_in    = sd7seg_pkg::ST_SKIP;
            end
         end
         sd7seg_pkg::ST_SKIP: begin
            // Drop leading zeros, keeping at least one digit
            if (top_digit == 4'd0 && !final_digit) begin
               digit_sr_in = {digit_sr_ff[sd7seg_pkg::BCD_WIDTH-5:0], 4'd0};
               left_in     = left_ff - sd7seg_pkg::DCNT_WIDTH'(1);
            end else begin
               state_in = sd7seg_pkg::ST_EMIT;
            end
         end
         sd7seg_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = {pos_ff, 1'b0};
               pos_in       = pos_ff + sd7seg_pkg::POS_WIDTH'(1);
               if (sign_pend_ff) begin
                  rsp_seg_in   = sd7seg_pkg::SEG_MINUS;
                  rsp_last_in  = 1'b0;
                  sign_pend_in = 1'b0;
               end else begin
                  rsp_seg_in  = sd7seg_pkg::seg_code(top_digit);
                  rsp_last_in = final_digit;
                  digit_sr_in = {digit_sr_ff[sd7seg_pkg::BCD_WIDTH-5:0], 4'd0};
                  left_in     = left_ff - sd7seg_pkg::DCNT_WIDTH'(1);
                  if (final_digit) begin
                     state_in = sd7seg_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = sd7seg_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sd7seg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload and working registers
   always_ff @(posedge clock) begin
      sign_pend_ff <= sign_pend_in;
      digit_sr_ff  <= digit_sr_in;
      left_ff      <= left_in;
      pos_ff       <= pos_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_seg_ff   <= rsp_seg_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_digit_address = rsp_addr_ff;
   assign rsp_segments      = rsp_seg_ff;
   assign rsp_last_char     = rsp_last_ff;

endmodule

`default_nettype wire

/* design/sd7seg_checker.sv */
// Port-level checker for the seven-segment writer, bound to the top level.
`default_nettype none

module sd7seg_checker (
   input wire logic                                      clock,
   input wire logic                                      reset,
   input wire logic                                      req_valid,
   input wire logic                                      req_stall,
   input wire logic signed [sd7seg_pkg::VALUE_WIDTH-1:0] req_value,
   input wire logic                                      rsp_valid,
   input wire logic                                      rsp_stall,
   input wire logic [sd7seg_pkg::ADDR_WIDTH-1:0]         rsp_digit_address,
   input wire logic [sd7seg_pkg::SEG_WIDTH-1:0]          rsp_segments,
   input wire logic                                      rsp_last_char
);

   // A stalled item stays valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled item keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_digit_address) && $stable(rsp_segments)
                                 && $stable(rsp_last_char))
      else $error("rsp payload changed while stalled");

   // One number at a time: after an accepted item the input stalls
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted during conversion");

   // The final character is always a digit, never the minus sign
   a_last_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> rsp_segments != sd7seg_pkg::SEG_MINUS)
      else $error("minus sign flagged as last character");

   // No leading zero in the leftmost position of a multi-character number
   a_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_digit_address == '0 && !rsp_last_char
      |-> rsp_segments != sd7seg_pkg::SEG_TABLE[0])
      else $error("leading zero written");

endmodule

bind signed_decimal_to_seven_segment sd7seg_checker u_sd7seg_checker (.*);

`default_nettype wire
